/* rtl/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the synchronous serial shift port: function
// codes, control register masks and read-back fill patterns.
// ----------------------------------------------------------------------------
package ssp_pkg;

  // request function codes
  typedef logic [2:0] func_t;
  localparam func_t FUNC_TICK      = 3'd0;
  localparam func_t FUNC_WR_CTL    = 3'd1;
  localparam func_t FUNC_WR_DATA   = 3'd2;
  localparam func_t FUNC_RD_CTL    = 3'd3;
  localparam func_t FUNC_RD_DATA   = 3'd4;
  localparam func_t FUNC_EXT_EDGE  = 3'd5;

  // control register layout
  localparam int unsigned CTL_START_BIT = 7;
  localparam int unsigned CTL_CLK_BIT   = 0;
  localparam int unsigned CTL_FAST_BIT  = 1;

  // writable bits and read-back fill, per color mode
  localparam logic [7:0] CTL_MASK_COLOR = 8'h83;
  localparam logic [7:0] CTL_MASK_PLAIN = 8'h81;
  localparam logic [7:0] CTL_FILL_COLOR = 8'h7C;
  localparam logic [7:0] CTL_FILL_PLAIN = 8'h7E;

  // bits in one transfer
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  function automatic logic [7:0] ctl_mask(input logic color);
    return color ? CTL_MASK_COLOR : CTL_MASK_PLAIN;
  endfunction

  function automatic logic [7:0] ctl_fill(input logic color);
    return color ? CTL_FILL_COLOR : CTL_FILL_PLAIN;
  endfunction

endpackage

/* rtl/ssp_ifs.sv */
// ----------------------------------------------------------------------------
// ssp channel interfaces
// Valid/ready channels of the serial shift port: request, response and the
// configuration write channel.
// ----------------------------------------------------------------------------

// request channel
interface ssp_req_if;
  logic            valid;
  logic            ready;
  ssp_pkg::func_t  func;
  logic [7:0]      wdata;
  logic [7:0]      tick_cycles;
  logic            serial_in;

  modport source(output valid, func, wdata, tick_cycles, serial_in, input ready);
  modport sink(input valid, func, wdata, tick_cycles, serial_in, output ready);
endinterface

// response channel
interface ssp_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rdata;
  logic        serial_out;
  logic        transfer_done;
  logic [7:0]  sent_byte;
  logic [7:0]  received_byte;

  modport source(output valid, rdata, serial_out, transfer_done, sent_byte,
                 received_byte, input ready);
  modport sink(input valid, rdata, serial_out, transfer_done, sent_byte,
               received_byte, output ready);
endinterface

// configuration write channel (color mode)
interface ssp_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

/* rtl/ssp_step_unit.sv */
// ----------------------------------------------------------------------------
// ssp_step_unit
// Shared compare-and-subtract unit: tests the bit phase against a period and
// gives the phase with one period taken off.
// ----------------------------------------------------------------------------
module ssp_step_unit #(
  parameter int unsigned PW = 10
) (
  input  logic [PW-1:0] value,
  input  logic [PW-1:0] period,
  output logic          ge,
  output logic [PW-1:0] diff
);

  // one wide subtract gives both the compare and the remainder
  logic [PW:0] sub;

  assign sub  = {1'b0, value} - {1'b0, period};
  assign ge   = ~sub[PW];
  assign diff = sub[PW-1:0];

endmodule

/* rtl/sync_serial_shift_port_unit.sv */
// ----------------------------------------------------------------------------
// sync_serial_shift_port_unit
// 8-bit synchronous serial port with data and control registers; the bit
// phase divider and shift sequencing run on one shared compare-subtract unit.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   func, wdata, tick_cycles, serial_in
//   rsp      out  valid/ready   rdata, serial_out, transfer_done, sent_byte,
//                               received_byte
//   cfg      in   valid/ready   data (color mode), always ready
//
// register and edge items go from the transfer into the finish state, which
// loads the result register once the output is free.
// a tick runs the shift loop while an internally clocked transfer is busy,
// one compare-subtract step of the shared unit per shifted bit, then, once
// no transfer runs, the wrap state, one step per wrap of the phase by
// SLOW_BIT_CYCLES; it then ends in the finish state.
// req is ready only when the sequencer is idle; a waiting result does not
// hold the sequencer, which parks the next result until the output is free.
// rst is synchronous and clears all port state and color mode.
// ----------------------------------------------------------------------------
module sync_serial_shift_port_unit #(
  parameter int unsigned SLOW_BIT_CYCLES = 512,
  parameter int unsigned FAST_BIT_CYCLES = 16
) (
  input  logic       clk,
  input  logic       rst,
  ssp_req_if.sink    req,
  ssp_rsp_if.source  rsp,
  ssp_cfg_if.sink    cfg
);

  localparam int unsigned MAXP = (SLOW_BIT_CYCLES > FAST_BIT_CYCLES) ?
                                 SLOW_BIT_CYCLES : FAST_BIT_CYCLES;
  localparam int unsigned PW   = $clog2(MAXP + 256);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOP = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]    state;
  logic          color_mode;

  // port state
  logic [7:0]    shift_reg;
  logic [7:0]    ctl;
  logic [PW-1:0] phase;
  logic [3:0]    bit_cnt;
  logic          busy;
  logic          clk_int;
  logic          fast;
  logic [7:0]    start_byte;

  // result being built
  logic [7:0]    res_rdata;
  logic          res_sout;
  logic          res_done;
  logic [7:0]    res_sent;
  logic [7:0]    res_recv;

  // output register
  logic          out_valid;
  logic [7:0]    out_rdata;
  logic          out_sout;
  logic          out_done;
  logic [7:0]    out_sent;
  logic [7:0]    out_recv;

  logic          accept;
  logic          out_free;
  logic [PW-1:0] step_period;
  logic          step_ge;
  logic [PW-1:0] step_diff;
  logic [7:0]    wr_masked;
  logic          do_shift;
  logic          in_bit;
  logic [7:0]    shifted;
  logic [3:0]    cnt_next;
  logic          done_now;
  logic [7:0]    rd_value;
  logic [PW-1:0] phase_sum;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  // shared compare-subtract: bit period in the shift loop, slow period in wrap
  always_comb begin
    if (state == ST_LOOP && fast) begin
      step_period = PW'(FAST_BIT_CYCLES);
    end else begin
      step_period = PW'(SLOW_BIT_CYCLES);
    end
  end

  ssp_step_unit #(.PW(PW)) u_step (
    .value  (phase),
    .period (step_period),
    .ge     (step_ge),
    .diff   (step_diff)
  );

  // shift control: external edge on transfer, internal bit in the loop
  always_comb begin
    wr_masked = req.wdata & ssp_pkg::ctl_mask(color_mode);
    phase_sum = phase + {{(PW-8){1'b0}}, req.tick_cycles};
    do_shift  = 1'b0;
    in_bit    = 1'b1;
    if (state == ST_LOOP) begin
      do_shift = busy && step_ge;
    end else if (accept && req.func == ssp_pkg::FUNC_EXT_EDGE) begin
      do_shift = busy && !clk_int;
      in_bit   = req.serial_in;
    end
    shifted  = {shift_reg[6:0], in_bit};
    cnt_next = bit_cnt + 4'd1;
    done_now = do_shift && (cnt_next == ssp_pkg::BITS_PER_BYTE);
  end

  // read-back value of a register read
  always_comb begin
    case (req.func)
      ssp_pkg::FUNC_RD_CTL: begin
        rd_value = ssp_pkg::ctl_fill(color_mode) |
                   (ctl & ssp_pkg::ctl_mask(color_mode));
      end
      ssp_pkg::FUNC_RD_DATA: begin
        rd_value = shift_reg;
      end
      default: begin
        rd_value = 8'h00;
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      color_mode <= cfg.data;
    end
  end

  // sequencer and port state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      shift_reg  <= '0;
      ctl        <= '0;
      phase      <= '0;
      bit_cnt    <= '0;
      busy       <= 1'b0;
      clk_int    <= 1'b0;
      fast       <= 1'b0;
      start_byte <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            // only an edge item can shift here
            res_rdata <= rd_value;
            res_sout  <= do_shift ? shift_reg[7] : 1'b1;
            res_done  <= done_now;
            res_sent  <= done_now ? start_byte : 8'h00;
            res_recv  <= done_now ? shifted : 8'h00;
            if (req.func == ssp_pkg::FUNC_TICK) begin
              state <= (busy && clk_int) ? ST_LOOP : ST_MOD;
            end else begin
              state <= ST_FIN;
            end
            case (req.func)
              ssp_pkg::FUNC_TICK: begin
                phase <= phase_sum;
              end
              ssp_pkg::FUNC_WR_CTL: begin
                ctl     <= wr_masked;
                bit_cnt <= '0;
                if (!wr_masked[ssp_pkg::CTL_START_BIT]) begin
                  busy  <= 1'b0;
                  phase <= '0;
                end else begin
                  busy       <= 1'b1;
                  clk_int    <= wr_masked[ssp_pkg::CTL_CLK_BIT];
                  fast       <= color_mode && wr_masked[ssp_pkg::CTL_FAST_BIT];
                  start_byte <= shift_reg;
                end
              end
              ssp_pkg::FUNC_WR_DATA: begin
                shift_reg <= req.wdata;
              end
              default: begin
              end
            endcase
          end
        end
        ST_LOOP: begin
          // one bit per cycle while the phase covers a full period
          if (do_shift) begin
            phase <= step_diff;
          end else if (!busy) begin
            state <= ST_MOD;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_MOD: begin
          // reduce the phase modulo the slow period
          if (step_ge) begin
            phase <= step_diff;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // shift register and bit counter, shared by edge and loop
      if (do_shift) begin
        shift_reg <= shifted;
        bit_cnt   <= cnt_next;
      end
      if (done_now) begin
        busy                        <= 1'b0;
        ctl[ssp_pkg::CTL_START_BIT] <= 1'b0;
        if (state == ST_LOOP) begin
          res_done <= 1'b1;
          res_sent <= start_byte;
          res_recv <= shifted;
        end
      end
    end
  end

  // output register, loaded when the sequencer finishes an item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_rdata <= res_rdata;
      out_sout  <= res_sout;
      out_done  <= res_done;
      out_sent  <= res_sent;
      out_recv  <= res_recv;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.rdata         = out_rdata;
  assign rsp.serial_out    = out_sout;
  assign rsp.transfer_done = out_done;
  assign rsp.sent_byte     = out_sent;
  assign rsp.received_byte = out_recv;

  // a transfer never counts past one byte
  a_bit_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    bit_cnt <= ssp_pkg::BITS_PER_BYTE)
    else $error("bit counter past one byte");

  // the shift loop only runs for an internally clocked transfer
  a_loop_internal: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOP) |-> clk_int)
    else $error("shift loop entered on external clock");

  // between items the phase is always below the larger period
  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (phase < PW'(MAXP)))
    else $error("bit phase left unreduced");

endmodule

/* tb/sync_serial_shift_port_unit_test.sv */
// ----------------------------------------------------------------------------
// sync_serial_shift_port_unit_test
// Self-checking bench for the serial shift port. A scoreboard class keeps its
// own model of the port, predicts one response per accepted request and
// compares every response field by field. Directed requests cover the corner
// cases, then randomized transfers run with random gaps and stalls on both
// channels over several color mode settings.
// ----------------------------------------------------------------------------
module sync_serial_shift_port_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOW_BIT_CYCLES = 512;
  localparam int unsigned FAST_BIT_CYCLES = 16;
  localparam ssp_pkg::func_t FUNC_UNUSED_LO = 3'd6;
  localparam ssp_pkg::func_t FUNC_UNUSED_HI = 3'd7;
  localparam int unsigned TARGET_ITEMS = 1750;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // expected response of one request
  typedef struct {
    logic [7:0] rdata;
    logic       serial_out;
    logic       done;
    logic [7:0] sent;
    logic [7:0] recv;
  } port_rsp_t;

  // port model plus queue of predicted responses
  class serial_port_scoreboard;
    port_rsp_t   expected_rsp[$];
    bit          color;
    logic [7:0]  shift_reg;
    logic [7:0]  ctl_reg;
    int unsigned phase_acc;
    logic [3:0]  bits_done;
    bit          port_busy;
    bit          internal_clk;
    bit          fast_clk;
    logic [7:0]  loaded_byte;
    int unsigned errors;
    int unsigned checked;

    function new();
      color = 1'b0;
      shift_reg = '0;
      ctl_reg = '0;
      phase_acc = 0;
      bits_done = '0;
      port_busy = 1'b0;
      internal_clk = 1'b0;
      fast_clk = 1'b0;
      loaded_byte = '0;
      errors = 0;
      checked = 0;
    endfunction

    // one bit into the shift register, closing the transfer on the eighth
    function void push_bit(logic b, ref port_rsp_t r);
      shift_reg = {shift_reg[6:0], b};
      bits_done = bits_done + 4'd1;
      if (bits_done == ssp_pkg::BITS_PER_BYTE) begin
        port_busy = 1'b0;
        ctl_reg[ssp_pkg::CTL_START_BIT] = 1'b0;
        r.done = 1'b1;
        r.sent = loaded_byte;
        r.recv = shift_reg;
      end
    endfunction

    function void note_request(ssp_pkg::func_t f, logic [7:0] w, logic [7:0] c,
                               logic s);
      port_rsp_t   r;
      logic [7:0]  mask;
      logic [7:0]  m;
      int unsigned period;
      r.rdata = '0;
      r.serial_out = 1'b1;
      r.done = 1'b0;
      r.sent = '0;
      r.recv = '0;
      mask = color ? ssp_pkg::CTL_MASK_COLOR : ssp_pkg::CTL_MASK_PLAIN;
      case (f)
        ssp_pkg::FUNC_TICK: begin
          if (!port_busy || !internal_clk) begin
            phase_acc = (phase_acc + c) % SLOW_BIT_CYCLES;
          end else begin
            period = fast_clk ? FAST_BIT_CYCLES : SLOW_BIT_CYCLES;
            phase_acc = phase_acc + c;
            while (port_busy && phase_acc >= period) begin
              phase_acc = phase_acc - period;
              push_bit(1'b1, r);
            end
            // keep leftover phase bounded once the transfer closed
            if (!port_busy && phase_acc >= SLOW_BIT_CYCLES)
              phase_acc = phase_acc % SLOW_BIT_CYCLES;
          end
        end
        ssp_pkg::FUNC_WR_CTL: begin
          m = w & mask;
          ctl_reg = m;
          if (!m[ssp_pkg::CTL_START_BIT]) begin
            port_busy = 1'b0;
            bits_done = '0;
            phase_acc = 0;
          end else begin
            internal_clk = m[ssp_pkg::CTL_CLK_BIT];
            port_busy = 1'b1;
            fast_clk = color && m[ssp_pkg::CTL_FAST_BIT];
            loaded_byte = shift_reg;
            bits_done = '0;
          end
        end
        ssp_pkg::FUNC_WR_DATA: shift_reg = w;
        ssp_pkg::FUNC_RD_CTL:
          r.rdata = (color ? ssp_pkg::CTL_FILL_COLOR : ssp_pkg::CTL_FILL_PLAIN) |
                    (ctl_reg & mask);
        ssp_pkg::FUNC_RD_DATA: r.rdata = shift_reg;
        ssp_pkg::FUNC_EXT_EDGE: begin
          if (port_busy && !internal_clk) begin
            r.serial_out = shift_reg[7];
            push_bit(s, r);
          end
        end
        default: ;
      endcase
      expected_rsp.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_response(logic [7:0] rd, logic so, logic dn, logic [7:0] sb,
                        logic [7:0] rb);
      port_rsp_t e;
      if (expected_rsp.size() == 0) begin
        report($sformatf("response %0d arrived with nothing expected", checked));
      end else begin
        e = expected_rsp.pop_front();
        if (rd !== e.rdata)
          report($sformatf("rsp %0d rdata %h, expected %h", checked, rd, e.rdata));
        if (so !== e.serial_out)
          report($sformatf("rsp %0d serial_out %b, expected %b", checked, so,
                           e.serial_out));
        if (dn !== e.done)
          report($sformatf("rsp %0d transfer_done %b, expected %b", checked, dn,
                           e.done));
        if (sb !== e.sent)
          report($sformatf("rsp %0d sent_byte %h, expected %h", checked, sb, e.sent));
        if (rb !== e.recv)
          report($sformatf("rsp %0d received_byte %h, expected %h", checked, rb,
                           e.recv));
      end
      checked++;
    endtask
  endclass

  logic clk;
  logic rst;
  bit steady;
  int unsigned sent_items;
  int unsigned quiet_cycles = 0;
  serial_port_scoreboard sb;

  ssp_req_if req_ch();
  ssp_rsp_if rsp_ch();
  ssp_cfg_if cfg_ch();

  sync_serial_shift_port_unit #(
    .SLOW_BIT_CYCLES(SLOW_BIT_CYCLES),
    .FAST_BIT_CYCLES(FAST_BIT_CYCLES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // response check and random back-pressure
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response(rsp_ch.rdata, rsp_ch.serial_out, rsp_ch.transfer_done,
                        rsp_ch.sent_byte, rsp_ch.received_byte);
    rsp_ch.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 7);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request transfer, with random gaps ahead of it
  task automatic send(ssp_pkg::func_t f, logic [7:0] w, logic [7:0] c, logic s);
    while (!steady && $urandom_range(0, 99) < 7) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= f;
    req_ch.wdata <= w;
    req_ch.tick_cycles <= c;
    req_ch.serial_in <= s;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(f, w, c, s);
    if (f <= ssp_pkg::FUNC_EXT_EDGE)
      sent_items++;
  endtask

  // color mode write, only once all responses are back
  task automatic set_color(bit v);
    req_ch.valid <= 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.color = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_noise();
    ssp_pkg::func_t f;
    f = ssp_pkg::func_t'($urandom_range(0, 7));
    send(f, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
         1'($urandom_range(0, 1)));
  endtask

  // a well-formed transfer with random content and occasional disturbances
  task automatic run_transfer();
    logic [7:0] ctl;
    int unsigned mode;
    int unsigned n;
    int unsigned k;
    logic [7:0] cyc;
    send(ssp_pkg::FUNC_WR_DATA, 8'($urandom_range(0, 255)),
         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    ctl = 8'($urandom_range(0, 255));
    ctl[ssp_pkg::CTL_START_BIT] = 1'b1;
    mode = $urandom_range(0, 2);
    ctl[ssp_pkg::CTL_CLK_BIT] = (mode != 0);
    ctl[ssp_pkg::CTL_FAST_BIT] = (mode == 2);
    send(ssp_pkg::FUNC_WR_CTL, ctl, 8'($urandom_range(0, 255)),
         1'($urandom_range(0, 1)));
    n = 0;
    while (sb.port_busy && n < 60) begin
      k = $urandom_range(0, 99);
      if (k < 8) begin
        send($urandom_range(0, 1) ? ssp_pkg::FUNC_RD_CTL : ssp_pkg::FUNC_RD_DATA,
             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
      end else if (k < 11) begin
        send(ssp_pkg::FUNC_WR_DATA, 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (k < 13) begin
        // abort with the start bit clear
        ctl = 8'($urandom_range(0, 255));
        ctl[ssp_pkg::CTL_START_BIT] = 1'b0;
        send(ssp_pkg::FUNC_WR_CTL, ctl, 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
      end else if (k < 16) begin
        // clock source that the transfer does not use
        if (sb.internal_clk)
          send(ssp_pkg::FUNC_EXT_EDGE, 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else
          send(ssp_pkg::FUNC_TICK, 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (sb.internal_clk) begin
        if (sb.fast_clk)
          cyc = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 40));
        else
          cyc = $urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(0, 255));
        send(ssp_pkg::FUNC_TICK, 8'($urandom_range(0, 255)), cyc,
             1'($urandom_range(0, 1)));
      end else begin
        send(ssp_pkg::FUNC_EXT_EDGE, 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      n++;
    end
  endtask

  initial begin
    bit colors[NUM_PHASES];
    int unsigned goal;
    int unsigned n;
    colors = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    sb = new();
    steady = 1'b0;
    sent_items = 0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.func <= ssp_pkg::FUNC_TICK;
    req_ch.wdata <= '0;
    req_ch.tick_cycles <= '0;
    req_ch.serial_in <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    set_color(1'b0);

    // reset values, unused codes, idle divider and idle edge
    send(ssp_pkg::FUNC_RD_CTL, 8'h00, 8'h00, 1'b0);
    send(ssp_pkg::FUNC_RD_DATA, 8'h00, 8'h00, 1'b0);
    send(FUNC_UNUSED_LO, 8'hFF, 8'hFF, 1'b1);
    send(FUNC_UNUSED_HI, 8'h00, 8'h00, 1'b0);
    send(ssp_pkg::FUNC_TICK, 8'h00, 8'h00, 1'b0);
    send(ssp_pkg::FUNC_TICK, 8'hFF, 8'hFF, 1'b1);
    send(ssp_pkg::FUNC_EXT_EDGE, 8'h00, 8'h00, 1'b1);
    send(ssp_pkg::FUNC_WR_DATA, 8'hFF, 8'h00, 1'b0);
    // external clock transfer with a data write in the middle
    send(ssp_pkg::FUNC_WR_DATA, 8'hA5, 8'h00, 1'b0);
    send(ssp_pkg::FUNC_WR_CTL, 8'h80, 8'h00, 1'b0);
    send(ssp_pkg::FUNC_EXT_EDGE, 8'h00, 8'h00, 1'b0);
    send(ssp_pkg::FUNC_EXT_EDGE, 8'h00, 8'h00, 1'b1);
    send(ssp_pkg::FUNC_EXT_EDGE, 8'h00, 8'h00, 1'b1);
    send(ssp_pkg::FUNC_WR_DATA, 8'h00, 8'h00, 1'b0);
    send(ssp_pkg::FUNC_RD_CTL, 8'h00, 8'h00, 1'b0);
    send(ssp_pkg::FUNC_EXT_EDGE, 8'h00, 8'h00, 1'b0);
    send(ssp_pkg::FUNC_EXT_EDGE, 8'h00, 8'h00, 1'b1);
    send(ssp_pkg::FUNC_EXT_EDGE, 8'h00, 8'h00, 1'b0);
    send(ssp_pkg::FUNC_EXT_EDGE, 8'h00, 8'h00, 1'b1);
    send(ssp_pkg::FUNC_EXT_EDGE, 8'h00, 8'h00, 1'b1);
    send(ssp_pkg::FUNC_EXT_EDGE, 8'h00, 8'h00, 1'b1);
    // internal clock: edge ignored, then stop mid-transfer
    send(ssp_pkg::FUNC_WR_CTL, 8'h81, 8'h00, 1'b0);
    send(ssp_pkg::FUNC_EXT_EDGE, 8'h00, 8'h00, 1'b1);
    send(ssp_pkg::FUNC_TICK, 8'h00, 8'hFF, 1'b0);
    send(ssp_pkg::FUNC_WR_CTL, 8'h7F, 8'h00, 1'b0);
    // fast burst from a high phase, leftover phase wraps
    set_color(1'b1);
    send(ssp_pkg::FUNC_TICK, 8'h00, 8'hFF, 1'b0);
    send(ssp_pkg::FUNC_TICK, 8'h00, 8'hFF, 1'b0);
    send(ssp_pkg::FUNC_WR_CTL, 8'hFF, 8'h00, 1'b0);
    send(ssp_pkg::FUNC_TICK, 8'h00, 8'hFF, 1'b0);
    send(ssp_pkg::FUNC_RD_CTL, 8'h00, 8'h00, 1'b0);
    // color mode drops mid-transfer, fast rate stays
    send(ssp_pkg::FUNC_WR_CTL, 8'h83, 8'h00, 1'b0);
    set_color(1'b0);
    send(ssp_pkg::FUNC_RD_CTL, 8'h00, 8'h00, 1'b0);
    send(ssp_pkg::FUNC_TICK, 8'h00, 8'hFF, 1'b0);

    // randomized phases, one color setting each, one without gaps or stalls
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_color(colors[p]);
      steady = (p == 2);
      goal = (p + 1) * TARGET_ITEMS / NUM_PHASES;
      while (sent_items < goal) begin
        if ($urandom_range(0, 99) < 15) begin
          n = $urandom_range(1, 4);
          repeat (n) send_noise();
        end else begin
          run_transfer();
        end
      end
    end
    steady = 1'b0;

    // drain
    req_ch.valid <= 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ssp_pkg.sv
rtl/ssp_ifs.sv
rtl/ssp_step_unit.sv
rtl/sync_serial_shift_port_unit.sv
tb/sync_serial_shift_port_unit_test.sv
